// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checking code of the block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CRS_AST_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CRS_AST_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/crs_pkg.sv -----
// Shared constants, controller states, datapath commands and status.
// No dependencies.
package crs_pkg;
  localparam int MaxPositions = 16384;
  localparam int WindowReset  = 50;
  localparam int DepthW       = 16;
  localparam int WsW          = 13;
  localparam int CountOutW    = 15;
  localparam int MeanW        = 24;

  typedef enum logic [4:0] {
    S_LOAD, S_SRT_START, S_SRT_RD0, S_SRT_RD1, S_SRT_STEP, S_SRT_TAIL,
    S_SH_START, S_SH_RD, S_SH_CMP, S_SM_RD, S_SM_ACC,
    S_WIN_START, S_WI_RD, S_WI_ACC, S_WS_RD, S_WS_UPD,
    S_DIV_GO, S_DIV_WT, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_CLEAR,
    OP_SRT_START, OP_SRT_RD0, OP_SRT_RD1, OP_SRT_STEP, OP_SRT_TAIL,
    OP_SH_START, OP_SH_RD, OP_SH_CMP, OP_SM_RD, OP_SM_ACC,
    OP_WIN_START, OP_WI_RD, OP_WI_ACC, OP_WS_RD, OP_WS_UPD,
    OP_DIV_GO, OP_DIV_WAIT
  } op_t;

  typedef enum logic [1:0] {SEL_SH, SEL_WMIN, SEL_WMAX, SEL_MEAN} div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic pass_done;
    logic sort_fin;
    logic sh_zero;
    logic last_half;
    logic win_skip;
    logic wi_last;
    logic ws_end;
    logic div_done;
  } status_t;
endpackage

// ----- rtl/crs_channels.sv -----
// Handshake channels for input words and result words.
// Depends on crs_pkg.
interface crs_in_if;
  logic                      valid;
  logic                      ready;
  logic [crs_pkg::DepthW-1:0] depth_value;
  logic                      last_position;
  modport source (output valid, depth_value, last_position, input ready);
  modport sink (input valid, depth_value, last_position, output ready);
endinterface

interface crs_out_if;
  logic                         valid;
  logic                         ready;
  logic [crs_pkg::CountOutW-1:0] position_count;
  logic [crs_pkg::MeanW-1:0]     mean_depth;
  logic [crs_pkg::MeanW-1:0]     shorth_mean_depth;
  logic [crs_pkg::MeanW-1:0]     window_min_mean;
  logic [crs_pkg::MeanW-1:0]     window_max_mean;
  modport source (output valid, position_count, mean_depth, shorth_mean_depth,
                  window_min_mean, window_max_mean, input ready);
  modport sink (input valid, position_count, mean_depth, shorth_mean_depth,
                window_min_mean, window_max_mean, output ready);
endinterface

// ----- rtl/crs_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module crs_div #(
  parameter int DW = 38,
  parameter int VW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CntW = $clog2(DW + 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [DW-1:0]   quo;
  logic [VW:0]     rem_sh;
  logic [VW:0]     diff;
  logic            ge;

  assign rem_sh   = {rem, quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CntW'(DW);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], ge};
      cnt <= cnt - CntW'(1);
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- rtl/crs_dpath.sv -----
// Datapath: depth store, sort carry, shorth and window scans, divider.
// Depends on crs_pkg and crs_div.
module crs_dpath #(
  parameter int MAX_POSITIONS = crs_pkg::MaxPositions
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crs_pkg::WsW-1:0]       cfg_wdata,
  input  crs_pkg::cmd_t                 cmd,
  input  logic [crs_pkg::DepthW-1:0]    depth_value,
  output crs_pkg::status_t              st,
  output logic [crs_pkg::CountOutW-1:0] position_count,
  output logic [crs_pkg::MeanW-1:0]     mean_depth,
  output logic [crs_pkg::MeanW-1:0]     shorth_mean_depth,
  output logic [crs_pkg::MeanW-1:0]     window_min_mean,
  output logic [crs_pkg::MeanW-1:0]     window_max_mean
);
  localparam int CNT_W  = $clog2(MAX_POSITIONS + 1);
  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int SUM_W  = crs_pkg::DepthW + CNT_W;
  localparam int VW     = (CNT_W > crs_pkg::WsW) ? CNT_W : crs_pkg::WsW;
  localparam int CW     = VW + 2;
  localparam int DW     = SUM_W + 8;
  localparam int MW     = crs_pkg::MeanW;

  logic [crs_pkg::DepthW-1:0] mem [MAX_POSITIONS];
  logic [crs_pkg::DepthW-1:0] rd0, rd1;
  logic [crs_pkg::WsW-1:0]    ws;
  logic [CNT_W-1:0]           count, idx, pass_end, best;
  logic [SUM_W-1:0]           sum, acc, wmin_s, wmax_s;
  logic [crs_pkg::DepthW-1:0] carry, best_diff;
  logic                       swapped;
  logic [MW-1:0]              shorth_q, wmin_q, wmax_q, mean_q;
  logic [crs_pkg::CountOutW-1:0] res_count;
  logic [MW-1:0]              res_mean, res_shorth, res_wmin, res_wmax;

  logic [CNT_W-1:0]           half;
  logic [CW-1:0]              cnt_x, idx_x, half_x, ws_x, upper_x, ws3_x;
  logic [CW-1:0]              ra0_x, ra1_x, wa_x;
  logic                       we, not_full, swap;
  logic [crs_pkg::DepthW-1:0] wd, gap;
  logic [SUM_W-1:0]           acc_add, slide;
  logic [SUM_W-1:0]           dnum;
  logic [VW-1:0]              dden;
  logic                       div_done;
  logic [DW-1:0]              quotient;
  logic [31:0]                cnt_ext;

  assign half     = count >> 1;
  assign cnt_x    = CW'(count);
  assign idx_x    = CW'(idx);
  assign half_x   = CW'(half);
  assign ws_x     = CW'(ws);
  assign ws3_x    = (ws_x << 1) + ws_x;
  assign upper_x  = cnt_x - (ws_x << 1);
  assign not_full = count < CNT_W'(MAX_POSITIONS);
  assign swap     = carry > rd0;
  assign gap      = rd1 - rd0;
  assign acc_add  = acc + SUM_W'(rd0);
  assign slide    = acc - SUM_W'(rd0) + SUM_W'(rd1);

  assign st.n_lt2     = count < CNT_W'(2);
  assign st.pass_done = idx == pass_end;
  assign st.sort_fin  = !swapped || (pass_end == CNT_W'(1));
  assign st.sh_zero   = half == '0;
  assign st.last_half = idx == half - CNT_W'(1);
  assign st.win_skip  = (ws == '0) || (ws3_x >= cnt_x);
  assign st.wi_last   = idx_x == ws_x - CW'(1);
  assign st.ws_end    = idx_x == upper_x;
  assign st.div_done  = div_done;

  always_comb begin
    ra0_x = '0;
    ra1_x = '0;
    case (cmd.op)
      crs_pkg::OP_SRT_RD1:  ra0_x = idx_x;
      crs_pkg::OP_SRT_STEP: ra0_x = idx_x + CW'(1);
      crs_pkg::OP_SH_RD: begin
        ra0_x = idx_x;
        ra1_x = idx_x + half_x - CW'(1);
      end
      crs_pkg::OP_SM_RD:    ra0_x = CW'(best) + idx_x;
      crs_pkg::OP_WI_RD:    ra0_x = ws_x + idx_x;
      crs_pkg::OP_WS_RD: begin
        ra0_x = idx_x - CW'(1);
        ra1_x = idx_x + ws_x - CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    we   = 1'b0;
    wa_x = '0;
    wd   = carry;
    case (cmd.op)
      crs_pkg::OP_LOAD: begin
        we   = not_full;
        wa_x = cnt_x;
        wd   = depth_value;
      end
      crs_pkg::OP_SRT_STEP: begin
        we   = 1'b1;
        wa_x = idx_x - CW'(1);
        wd   = swap ? rd0 : carry;
      end
      crs_pkg::OP_SRT_TAIL: begin
        we   = 1'b1;
        wa_x = CW'(pass_end);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa_x[ADDR_W-1:0]] <= wd;
    end
    rd0 <= mem[ra0_x[ADDR_W-1:0]];
    rd1 <= mem[ra1_x[ADDR_W-1:0]];
  end

  always_comb begin
    case (cmd.sel)
      crs_pkg::SEL_SH: begin
        dnum = acc;
        dden = VW'(half);
      end
      crs_pkg::SEL_WMIN: begin
        dnum = wmin_s;
        dden = VW'(ws);
      end
      crs_pkg::SEL_WMAX: begin
        dnum = wmax_s;
        dden = VW'(ws);
      end
      default: begin
        dnum = sum;
        dden = VW'(count);
      end
    endcase
  end

  crs_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == crs_pkg::OP_DIV_GO),
    .dividend ({dnum, 8'h00}),
    .divisor  (dden),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ws    <= crs_pkg::WsW'(crs_pkg::WindowReset);
      count <= '0;
      sum   <= '0;
    end else begin
      if (cfg_we) begin
        ws <= cfg_wdata;
      end
      case (cmd.op)
        crs_pkg::OP_LOAD: begin
          if (not_full) begin
            count <= count + CNT_W'(1);
            sum   <= sum + SUM_W'(depth_value);
          end
        end
        crs_pkg::OP_CLEAR: begin
          count <= '0;
          sum   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      crs_pkg::OP_SRT_START: begin
        pass_end <= count - CNT_W'(1);
        swapped  <= 1'b0;
      end
      crs_pkg::OP_SRT_RD0: idx <= CNT_W'(1);
      crs_pkg::OP_SRT_RD1: carry <= rd0;
      crs_pkg::OP_SRT_STEP: begin
        if (swap) begin
          swapped <= 1'b1;
        end else begin
          carry <= rd0;
        end
        if (idx != pass_end) begin
          idx <= idx + CNT_W'(1);
        end
      end
      crs_pkg::OP_SRT_TAIL: begin
        pass_end <= pass_end - CNT_W'(1);
        swapped  <= 1'b0;
      end
      crs_pkg::OP_SH_START: begin
        idx <= '0;
        if (half == '0) begin
          shorth_q <= '0;
        end
      end
      crs_pkg::OP_SH_CMP: begin
        if (idx == '0 || gap < best_diff) begin
          best      <= idx;
          best_diff <= gap;
        end
        if (st.last_half) begin
          idx <= '0;
          acc <= '0;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
      crs_pkg::OP_SM_ACC: begin
        acc <= acc_add;
        idx <= idx + CNT_W'(1);
      end
      crs_pkg::OP_WIN_START: begin
        idx <= '0;
        acc <= '0;
        if (st.win_skip) begin
          wmin_q <= '0;
          wmax_q <= '0;
        end
      end
      crs_pkg::OP_WI_ACC: begin
        acc <= acc_add;
        if (st.wi_last) begin
          idx    <= CNT_W'(ws_x + CW'(1));
          wmin_s <= acc_add;
          wmax_s <= acc_add;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
      crs_pkg::OP_WS_UPD: begin
        acc <= slide;
        idx <= idx + CNT_W'(1);
        if (slide < wmin_s) begin
          wmin_s <= slide;
        end
        if (slide > wmax_s) begin
          wmax_s <= slide;
        end
      end
      crs_pkg::OP_DIV_WAIT: begin
        if (div_done) begin
          case (cmd.sel)
            crs_pkg::SEL_SH:   shorth_q <= quotient[MW-1:0];
            crs_pkg::SEL_WMIN: wmin_q   <= quotient[MW-1:0];
            crs_pkg::SEL_WMAX: wmax_q   <= quotient[MW-1:0];
            default:           mean_q   <= quotient[MW-1:0];
          endcase
        end
      end
      crs_pkg::OP_CLEAR: begin
        res_count  <= cnt_ext[crs_pkg::CountOutW-1:0];
        res_mean   <= mean_q;
        res_shorth <= shorth_q;
        res_wmin   <= wmin_q;
        res_wmax   <= wmax_q;
      end
      default: ;
    endcase
  end

  assign cnt_ext           = 32'(count);
  assign position_count    = res_count;
  assign mean_depth        = res_mean;
  assign shorth_mean_depth = res_shorth;
  assign window_min_mean   = res_wmin;
  assign window_max_mean   = res_wmax;
endmodule

// ----- rtl/crs_ctrl.sv -----
// Controller: sequences load, sort passes, scans and divides.
// Depends on crs_pkg.
module crs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  input  logic             out_ready,
  input  crs_pkg::status_t st,
  output crs_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);
  crs_pkg::state_t   state, state_next;
  crs_pkg::div_sel_t sel, sel_next;
  logic              out_full;
  logic              publish;

  assign publish = (state == crs_pkg::S_OUT) && (!out_full || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crs_pkg::S_LOAD;
      sel   <= crs_pkg::SEL_SH;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (publish) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      crs_pkg::S_LOAD: begin
        if (in_valid && in_last) begin
          state_next = crs_pkg::S_SRT_START;
        end
      end
      crs_pkg::S_SRT_START:
        state_next = st.n_lt2 ? crs_pkg::S_SH_START : crs_pkg::S_SRT_RD0;
      crs_pkg::S_SRT_RD0: state_next = crs_pkg::S_SRT_RD1;
      crs_pkg::S_SRT_RD1: state_next = crs_pkg::S_SRT_STEP;
      crs_pkg::S_SRT_STEP: begin
        if (st.pass_done) begin
          state_next = crs_pkg::S_SRT_TAIL;
        end
      end
      crs_pkg::S_SRT_TAIL:
        state_next = st.sort_fin ? crs_pkg::S_SH_START : crs_pkg::S_SRT_RD0;
      crs_pkg::S_SH_START:
        state_next = st.sh_zero ? crs_pkg::S_WIN_START : crs_pkg::S_SH_RD;
      crs_pkg::S_SH_RD: state_next = crs_pkg::S_SH_CMP;
      crs_pkg::S_SH_CMP:
        state_next = st.last_half ? crs_pkg::S_SM_RD : crs_pkg::S_SH_RD;
      crs_pkg::S_SM_RD: state_next = crs_pkg::S_SM_ACC;
      crs_pkg::S_SM_ACC: begin
        if (st.last_half) begin
          state_next = crs_pkg::S_DIV_GO;
          sel_next   = crs_pkg::SEL_SH;
        end else begin
          state_next = crs_pkg::S_SM_RD;
        end
      end
      crs_pkg::S_WIN_START: begin
        if (st.win_skip) begin
          state_next = crs_pkg::S_DIV_GO;
          sel_next   = crs_pkg::SEL_MEAN;
        end else begin
          state_next = crs_pkg::S_WI_RD;
        end
      end
      crs_pkg::S_WI_RD: state_next = crs_pkg::S_WI_ACC;
      crs_pkg::S_WI_ACC:
        state_next = st.wi_last ? crs_pkg::S_WS_RD : crs_pkg::S_WI_RD;
      crs_pkg::S_WS_RD: begin
        if (st.ws_end) begin
          state_next = crs_pkg::S_DIV_GO;
          sel_next   = crs_pkg::SEL_WMIN;
        end else begin
          state_next = crs_pkg::S_WS_UPD;
        end
      end
      crs_pkg::S_WS_UPD: state_next = crs_pkg::S_WS_RD;
      crs_pkg::S_DIV_GO: state_next = crs_pkg::S_DIV_WT;
      crs_pkg::S_DIV_WT: begin
        if (st.div_done) begin
          case (sel)
            crs_pkg::SEL_SH: state_next = crs_pkg::S_WIN_START;
            crs_pkg::SEL_WMIN: begin
              state_next = crs_pkg::S_DIV_GO;
              sel_next   = crs_pkg::SEL_WMAX;
            end
            crs_pkg::SEL_WMAX: begin
              state_next = crs_pkg::S_DIV_GO;
              sel_next   = crs_pkg::SEL_MEAN;
            end
            default: state_next = crs_pkg::S_OUT;
          endcase
        end
      end
      crs_pkg::S_OUT: begin
        if (publish) begin
          state_next = crs_pkg::S_LOAD;
        end
      end
      default: state_next = crs_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd.op    = crs_pkg::OP_IDLE;
    cmd.sel   = sel;
    in_ready  = 1'b0;
    out_valid = out_full;
    case (state)
      crs_pkg::S_LOAD: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? crs_pkg::OP_LOAD : crs_pkg::OP_IDLE;
      end
      crs_pkg::S_SRT_START: cmd.op = crs_pkg::OP_SRT_START;
      crs_pkg::S_SRT_RD0:   cmd.op = crs_pkg::OP_SRT_RD0;
      crs_pkg::S_SRT_RD1:   cmd.op = crs_pkg::OP_SRT_RD1;
      crs_pkg::S_SRT_STEP:  cmd.op = crs_pkg::OP_SRT_STEP;
      crs_pkg::S_SRT_TAIL:  cmd.op = crs_pkg::OP_SRT_TAIL;
      crs_pkg::S_SH_START:  cmd.op = crs_pkg::OP_SH_START;
      crs_pkg::S_SH_RD:     cmd.op = crs_pkg::OP_SH_RD;
      crs_pkg::S_SH_CMP:    cmd.op = crs_pkg::OP_SH_CMP;
      crs_pkg::S_SM_RD:     cmd.op = crs_pkg::OP_SM_RD;
      crs_pkg::S_SM_ACC:    cmd.op = crs_pkg::OP_SM_ACC;
      crs_pkg::S_WIN_START: cmd.op = crs_pkg::OP_WIN_START;
      crs_pkg::S_WI_RD:     cmd.op = crs_pkg::OP_WI_RD;
      crs_pkg::S_WI_ACC:    cmd.op = crs_pkg::OP_WI_ACC;
      crs_pkg::S_WS_RD:     cmd.op = crs_pkg::OP_WS_RD;
      crs_pkg::S_WS_UPD:    cmd.op = crs_pkg::OP_WS_UPD;
      crs_pkg::S_DIV_GO:    cmd.op = crs_pkg::OP_DIV_GO;
      crs_pkg::S_DIV_WT:    cmd.op = crs_pkg::OP_DIV_WAIT;
      crs_pkg::S_OUT:       cmd.op = publish ? crs_pkg::OP_CLEAR : crs_pkg::OP_IDLE;
      default: ;
    endcase
  end
endmodule

// ----- rtl/coverage_robust_stats_core.sv -----
// Top level of the robust read-depth statistics block.
// Depends on crs_pkg, crs_channels, crs_ctrl, crs_dpath and assert_macros.svh.
//
// Depth words load at one per cycle into a single-write, dual-read store of
// MAX_POSITIONS entries. After the word marked last, the store is sorted by
// carry-bubble passes over the write port; passes stop early once a pass
// makes no exchange. The shorth scan and the window scan then run, and up to
// four divides produce the means. The result word moves into an output
// register, so the next sequence loads while it waits; a finished sequence
// holds until that register is free.
`include "assert_macros.svh"
module coverage_robust_stats_core #(
  parameter int MAX_POSITIONS = crs_pkg::MaxPositions
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [crs_pkg::WsW-1:0] cfg_wdata,
  crs_in_if.sink                  in_ch,
  crs_out_if.source               out_ch
);
  crs_pkg::cmd_t    cmd;
  crs_pkg::status_t st;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_position),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  crs_dpath #(.MAX_POSITIONS(MAX_POSITIONS)) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .depth_value       (in_ch.depth_value),
    .st                (st),
    .position_count    (out_ch.position_count),
    .mean_depth        (out_ch.mean_depth),
    .shorth_mean_depth (out_ch.shorth_mean_depth),
    .window_min_mean   (out_ch.window_min_mean),
    .window_max_mean   (out_ch.window_max_mean)
  );

  `CRS_AST_NXT(a_busy_after_last, clk, rst,
    in_ch.valid && in_ch.ready && in_ch.last_position, !in_ch.ready)
  `CRS_AST_NXT(a_hold_out, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `CRS_AST_NXT(a_stable_out, clk, rst, out_ch.valid && !out_ch.ready,
    $stable(out_ch.position_count) && $stable(out_ch.mean_depth))
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for coverage_robust_stats_core: random and directed
// depth sequences, predicted sequence statistics checked against result words.
// Depends on crs_pkg, crs_channels and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam int WatchdogLimit = 400000;

  typedef struct {
    logic [crs_pkg::DepthW-1:0] depth;
    logic                       last;
  } depth_word_t;

  typedef struct {
    logic [crs_pkg::CountOutW-1:0] count;
    logic [crs_pkg::MeanW-1:0]     mean;
    logic [crs_pkg::MeanW-1:0]     shorth;
    logic [crs_pkg::MeanW-1:0]     wmin;
    logic [crs_pkg::MeanW-1:0]     wmax;
  } stats_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [crs_pkg::WsW-1:0] cfg_wdata = '0;

  crs_in_if  din ();
  crs_out_if dout ();

  coverage_robust_stats_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(din), .out_ch(dout)
  );

  depth_word_t                pending_words[$];
  stats_t                     expected_stats[$];
  logic [crs_pkg::DepthW-1:0] seq_depths[$];
  int unsigned                window_len = crs_pkg::WindowReset;
  int unsigned                send_idle_pct = 0;
  int unsigned                recv_stall_pct = 0;
  bit                         send_hold = 1'b0;
  int unsigned                errors = 0;
  int unsigned                quiet_cycles = 0;

  initial begin
    din.valid = 1'b0;
    din.depth_value = '0;
    din.last_position = 1'b0;
    dout.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] q8_div(logic [63:0] sum, int unsigned n);
    if (n == 0) return 0;
    return (sum << 8) / n;
  endfunction

  function automatic stats_t sequence_stats(logic [crs_pkg::DepthW-1:0] vals[$],
                                            int unsigned ws);
    stats_t r;
    logic [crs_pkg::DepthW-1:0] s[$];
    int unsigned n, half, best, bd, d, upper;
    logic [63:0] total, acc, m, mn, mx, q;
    s = vals;
    s.sort();
    n = s.size();
    total = 0;
    foreach (s[i]) total += 64'(s[i]);
    r.count = n[crs_pkg::CountOutW-1:0];
    q = q8_div(total, n);
    r.mean = q[crs_pkg::MeanW-1:0];
    half = n / 2;
    r.shorth = 0;
    if (half > 0) begin
      best = 0;
      bd = 32'(s[half-1]) - 32'(s[0]);
      for (int i = 1; i < half; i++) begin
        d = 32'(s[i+half-1]) - 32'(s[i]);
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
      acc = 0;
      for (int i = 0; i < half; i++) acc += 64'(s[best+i]);
      q = q8_div(acc, half);
      r.shorth = q[crs_pkg::MeanW-1:0];
    end
    mn = 0;
    mx = 0;
    if (ws != 0 && n > 2 * ws) begin
      upper = n - 2 * ws;
      for (int i = ws; i < upper; i++) begin
        acc = 0;
        for (int k = 0; k < ws; k++) acc += 64'(s[i+k]);
        m = q8_div(acc, ws);
        if (i == ws) begin
          mn = m;
          mx = m;
        end else begin
          if (m > mx) mx = m;
          if (m < mn) mn = m;
        end
      end
    end
    r.wmin = mn[crs_pkg::MeanW-1:0];
    r.wmax = mx[crs_pkg::MeanW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else if (!din.valid || din.ready) begin
      if (din.valid) begin
        seq_depths.push_back(pending_words[0].depth);
        if (pending_words[0].last) begin
          expected_stats.push_back(sequence_stats(seq_depths, window_len));
          seq_depths.delete();
        end
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        din.valid <= 1'b1;
        din.depth_value <= pending_words[0].depth;
        din.last_position <= pending_words[0].last;
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (dout.valid && dout.ready) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result word count=%0d", $time, dout.position_count);
          errors++;
        end else begin
          if (dout.position_count !== expected_stats[0].count) begin
            $display("%0t: position_count expected %0d actual %0d", $time,
                     expected_stats[0].count, dout.position_count);
            errors++;
          end
          if (dout.mean_depth !== expected_stats[0].mean) begin
            $display("%0t: mean_depth expected %0h actual %0h", $time,
                     expected_stats[0].mean, dout.mean_depth);
            errors++;
          end
          if (dout.shorth_mean_depth !== expected_stats[0].shorth) begin
            $display("%0t: shorth_mean_depth expected %0h actual %0h", $time,
                     expected_stats[0].shorth, dout.shorth_mean_depth);
            errors++;
          end
          if (dout.window_min_mean !== expected_stats[0].wmin) begin
            $display("%0t: window_min_mean expected %0h actual %0h", $time,
                     expected_stats[0].wmin, dout.window_min_mean);
            errors++;
          end
          if (dout.window_max_mean !== expected_stats[0].wmax) begin
            $display("%0t: window_max_mean expected %0h actual %0h", $time,
                     expected_stats[0].wmax, dout.window_max_mean);
            errors++;
          end
          void'(expected_stats.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((din.valid && din.ready) || (dout.valid && dout.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(logic [crs_pkg::DepthW-1:0] v, logic last);
    depth_word_t w;
    w.depth = v;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic push_sequence(int unsigned n);
    int unsigned mode;
    logic [crs_pkg::DepthW-1:0] v;
    mode = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'($urandom_range(7));
        2: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: v = 16'd1000 + 16'($urandom_range(40));
      endcase
      push_word(v, i == n - 1);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || din.valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [crs_pkg::WsW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_len = 32'(v);
  endtask

  initial begin
    int unsigned words;
    int unsigned len;
    int unsigned stall_sets[4][2];
    logic [crs_pkg::WsW-1:0] ws_sets[8];
    stall_sets = '{'{0, 0}, '{49, 0}, '{0, 49}, '{26, 26}};
    ws_sets = '{13'd1, 13'd2, 13'd3, 13'd4096, 13'd0, 13'd8191, 13'd50, 13'd5};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_word(16'hFFFF, 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'd9, 1'b0);
    push_word(16'd3, 1'b0);
    push_word(16'd9, 1'b0);
    push_word(16'd3, 1'b0);
    push_word(16'd6, 1'b1);
    drain();
    write_window(13'd1);
    for (int i = 0; i < 12; i++) push_word(i[0] ? 16'hFFFF : 16'h5555 + 16'(i), i == 11);
    drain();
    write_window(13'd0);
    for (int i = 0; i < 5; i++) push_word(16'hAAAA >> i, i == 4);
    drain();

    words = 0;
    for (int ph = 0; ph < 16; ph++) begin
      send_idle_pct = stall_sets[ph % 4][0];
      recv_stall_pct = stall_sets[ph % 4][1];
      write_window(ws_sets[ph % 8]);
      for (int k = 0; k < 4; k++) begin
        if (k == 2) begin
          drain();
          send_hold = 1'b1;
        end
        len = (ph == 6 && k == 0) ? 256 : $urandom_range(1, 20);
        if (window_len < 8 && $urandom_range(1)) len = $urandom_range(1, 40);
        push_sequence(len);
        words += len;
        if (k == 2) send_hold = 1'b0;
      end
      if (ph % 3 == 0 && words < 1300) push_sequence($urandom_range(20, 60));
      drain();
    end
    while (words < 1300) begin
      len = $urandom_range(1, 30);
      push_sequence(len);
      words += len;
    end
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
